[rtl/mpeg1iq_pkg.sv]
// Shared types, constants, the zigzag scan table and the default intra weights of the MPEG-1 inverse quantizer.
package mpeg1iq_pkg;

	localparam int COEFFS_PER_BLOCK = 64;
	localparam int POS_W = $clog2(COEFFS_PER_BLOCK);
	localparam int ADDR_W = 16;
	localparam int COEF_W = 9;
	localparam int WEIGHT_W = 8;
	localparam int QS_W = 5;
	localparam int BLK_W = 3;
	localparam int RECON_W = 13;
	localparam int BASE_W = 10;
	localparam int M1_W = 14;
	localparam int PROD_W = 22;
	localparam int MAG_W = 19;

	localparam logic signed [RECON_W-1:0] PRED_RESET = 13'sd1024;
	localparam logic signed [RECON_W:0] DC_MAX = 14'sd4095;
	localparam logic signed [RECON_W:0] DC_MIN = -14'sd4096;
	localparam logic [MAG_W-1:0] AC_POS_MAX = 19'd2047;
	localparam logic [MAG_W-1:0] AC_NEG_MAX = 19'd2048;
	localparam logic [WEIGHT_W-1:0] NONINTRA_DEFAULT = 8'd16;

	typedef enum logic [1:0] {
		REQ_COEF          = 2'd0,
		REQ_LOAD_INTRA    = 2'd1,
		REQ_LOAD_NONINTRA = 2'd2,
		REQ_SLICE         = 2'd3
	} req_kind_t;

	// Classified item as it travels from the front end to the back end.
	typedef struct packed {
		req_kind_t                  kind;
		logic [POS_W-1:0]           pos;
		logic signed [COEF_W-1:0]   coefficient;
		logic                       negative;
		logic [M1_W-1:0]            m1;
		logic [WEIGHT_W-1:0]        weight;
		logic                       intra;
		logic                       is_dc;
		logic [BLK_W-1:0]           block_num;
		logic [ADDR_W-1:0]          mb_address;
		logic                       last;
	} iq_item_t;

	localparam logic [POS_W-1:0] ZZ_TO_NAT [COEFFS_PER_BLOCK] = '{
		6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10,
		6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4, 6'd5,
		6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
		6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28,
		6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
		6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
		6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
		6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
	};

	localparam logic [WEIGHT_W-1:0] INTRA_DEFAULT [COEFFS_PER_BLOCK] = '{
		8'd8, 8'd16, 8'd19, 8'd22, 8'd26, 8'd27, 8'd29, 8'd34,
		8'd16, 8'd16, 8'd22, 8'd24, 8'd27, 8'd29, 8'd34, 8'd37,
		8'd19, 8'd22, 8'd26, 8'd27, 8'd29, 8'd34, 8'd34, 8'd38,
		8'd22, 8'd22, 8'd26, 8'd27, 8'd29, 8'd34, 8'd37, 8'd40,
		8'd22, 8'd26, 8'd27, 8'd29, 8'd32, 8'd35, 8'd40, 8'd48,
		8'd26, 8'd27, 8'd29, 8'd32, 8'd35, 8'd40, 8'd48, 8'd58,
		8'd26, 8'd27, 8'd29, 8'd34, 8'd38, 8'd46, 8'd56, 8'd69,
		8'd27, 8'd29, 8'd35, 8'd38, 8'd46, 8'd56, 8'd69, 8'd83
	};

endpackage

[rtl/mpeg1iq_if.sv]
// Handshake channels for the inverse quantizer's input items and results.
interface mpeg1iq_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [5:0]        index;
	logic signed [8:0] coefficient;
	logic [7:0]        weight;
	logic [4:0]        quant_scale;
	logic              intra;
	logic [2:0]        block_num;
	logic [15:0]       mb_address;
	logic              last_in_block;

	modport source(output valid, req_type, index, coefficient, weight, quant_scale, intra,
		block_num, mb_address, last_in_block, input ready);
	modport sink(input valid, req_type, index, coefficient, weight, quant_scale, intra,
		block_num, mb_address, last_in_block, output ready);
endinterface

interface mpeg1iq_out_if;
	logic               valid;
	logic               ready;
	logic signed [12:0] recon_value;
	logic [5:0]         position;
	logic               block_end;

	modport source(output valid, recon_value, position, block_end, input ready);
	modport sink(input valid, recon_value, position, block_end, output ready);
endinterface

[rtl/mpeg1iq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mpeg1iq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/mpeg1iq_front.sv]
// Front end: classifies input beats, maps the scan order and forms the first product.
module mpeg1iq_front import mpeg1iq_pkg::*; (
	mpeg1iq_in_if.sink item,
	input  logic       fifo_ready,
	output logic       push,
	output iq_item_t   push_item
);

	req_kind_t         kind;
	logic [BASE_W-1:0] mag;
	logic [BASE_W-1:0] base;

	assign kind = req_kind_t'(item.req_type);
	assign item.ready = fifo_ready;
	assign push = item.valid && fifo_ready;

	always_comb begin
		mag = item.coefficient[COEF_W-1] ? BASE_W'(-{item.coefficient[COEF_W-1], item.coefficient})
			: BASE_W'({1'b0, item.coefficient});
		if (item.intra) begin
			base = mag;
		end else begin
			base = BASE_W'({mag[BASE_W-2:0], 1'b0}) + BASE_W'(mag != '0);
		end

		push_item.kind        = kind;
		push_item.pos         = (kind == REQ_COEF) ? ZZ_TO_NAT[item.index] : item.index;
		push_item.coefficient = item.coefficient;
		push_item.negative    = item.coefficient[COEF_W-1];
		push_item.m1          = M1_W'({{QS_W{1'b0}}, base} * {{BASE_W{1'b0}}, item.quant_scale});
		push_item.weight      = item.weight;
		push_item.intra       = item.intra;
		push_item.is_dc       = item.intra && (item.index == '0);
		push_item.block_num   = item.block_num;
		push_item.mb_address  = item.mb_address;
		push_item.last        = item.last_in_block;
	end

endmodule

[rtl/mpeg1iq_fifo.sv]
// Two-entry queue between the front end and the back end.
module mpeg1iq_fifo import mpeg1iq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  iq_item_t push_item,
	output logic     push_ready,
	input  logic     pop,
	output logic     pop_valid,
	output iq_item_t pop_item
);

	iq_item_t   entry_q [2];
	logic       head_q;
	logic       tail_q;
	logic [1:0] count_q;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item = entry_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			tail_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				tail_q <= !tail_q;
			end
			if (pop) begin
				head_q <= !head_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[tail_q] <= push_item;
		end
	end

endmodule

[rtl/mpeg1iq_back.sv]
// Back end: weight tables, DC prediction, weight multiply, rounding and clamping.
module mpeg1iq_back import mpeg1iq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pop_valid,
	input  iq_item_t pop_item,
	output logic     pop,
	mpeg1iq_out_if.source result
);

	logic                         adv;
	logic                         coef_pop;
	logic                         we_intra;
	logic                         we_nonintra;
	logic [WEIGHT_W-1:0]          rd_intra;
	logic [WEIGHT_W-1:0]          rd_nonintra;
	logic [COEFFS_PER_BLOCK-1:0]  ivld_q;
	logic [COEFFS_PER_BLOCK-1:0]  nvld_q;
	logic signed [RECON_W-1:0]    pred_luma_q;
	logic signed [RECON_W-1:0]    pred_cb_q;
	logic signed [RECON_W-1:0]    pred_cr_q;
	logic [ADDR_W-1:0]            past_addr_q;
	logic                         past_valid_q;
	logic signed [ADDR_W:0]       addr_diff;
	logic                         restart;
	logic signed [RECON_W-1:0]    pred;
	logic signed [RECON_W:0]      dc_sum;
	logic signed [RECON_W-1:0]    dc_val;

	logic                         vld_s1;
	logic                         is_dc_s1;
	logic signed [RECON_W-1:0]    dc_s1;
	logic                         intra_s1;
	logic                         neg_s1;
	logic [M1_W-1:0]              m1_s1;
	logic [POS_W-1:0]             pos_s1;
	logic                         last_s1;
	logic                         wvld_s1;
	logic [WEIGHT_W-1:0]          wdef_s1;
	logic [WEIGHT_W-1:0]          weight_s1;

	logic                         vld_s2;
	logic                         is_dc_s2;
	logic signed [RECON_W-1:0]    dc_s2;
	logic                         intra_s2;
	logic                         neg_s2;
	logic [PROD_W-1:0]            prod_s2;
	logic [POS_W-1:0]             pos_s2;
	logic                         last_s2;

	logic [MAG_W-1:0]             mag;
	logic [MAG_W-1:0]             mag_odd;
	logic signed [RECON_W-1:0]    ac_val;

	logic                         out_vld_q;
	logic signed [RECON_W-1:0]    recon_q;
	logic [POS_W-1:0]             position_q;
	logic                         block_end_q;

	assign adv = !out_vld_q || result.ready;
	assign pop = pop_valid && adv;
	assign coef_pop = pop && (pop_item.kind == REQ_COEF);
	assign we_intra = pop && (pop_item.kind == REQ_LOAD_INTRA);
	assign we_nonintra = pop && (pop_item.kind == REQ_LOAD_NONINTRA);

	mpeg1iq_ram #(.WIDTH(WEIGHT_W), .DEPTH(COEFFS_PER_BLOCK)) u_intra_ram (
		.clk(clk),
		.we(we_intra),
		.waddr(pop_item.pos),
		.wdata(pop_item.weight),
		.re(coef_pop),
		.raddr(pop_item.pos),
		.rdata(rd_intra)
	);

	mpeg1iq_ram #(.WIDTH(WEIGHT_W), .DEPTH(COEFFS_PER_BLOCK)) u_nonintra_ram (
		.clk(clk),
		.we(we_nonintra),
		.waddr(pop_item.pos),
		.wdata(pop_item.weight),
		.re(coef_pop),
		.raddr(pop_item.pos),
		.rdata(rd_nonintra)
	);

	// The DC predictors restart (luma at block 0 only) when no intra macroblock was seen or the last one is not adjacent.
	always_comb begin
		addr_diff = $signed({1'b0, pop_item.mb_address}) - $signed({1'b0, past_addr_q});
		restart = !past_valid_q || (addr_diff > 17'sd1);
		if (!pop_item.block_num[2]) begin
			pred = (pop_item.block_num == '0 && restart) ? PRED_RESET : pred_luma_q;
		end else if (pop_item.block_num == 3'd4) begin
			pred = restart ? PRED_RESET : pred_cb_q;
		end else begin
			pred = restart ? PRED_RESET : pred_cr_q;
		end
		dc_sum = {{2{pop_item.coefficient[COEF_W-1]}}, pop_item.coefficient, 3'b000}
			+ {pred[RECON_W-1], pred};
		if (dc_sum > DC_MAX) begin
			dc_val = DC_MAX[RECON_W-1:0];
		end else if (dc_sum < DC_MIN) begin
			dc_val = DC_MIN[RECON_W-1:0];
		end else begin
			dc_val = dc_sum[RECON_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ivld_q <= '0;
			nvld_q <= '0;
			pred_luma_q <= PRED_RESET;
			pred_cb_q <= PRED_RESET;
			pred_cr_q <= PRED_RESET;
			past_addr_q <= '0;
			past_valid_q <= 1'b0;
		end else if (pop) begin
			unique case (pop_item.kind)
				REQ_LOAD_INTRA: begin
					ivld_q[pop_item.pos] <= 1'b1;
				end
				REQ_LOAD_NONINTRA: begin
					nvld_q[pop_item.pos] <= 1'b1;
				end
				REQ_SLICE: begin
					pred_luma_q <= PRED_RESET;
					pred_cb_q <= PRED_RESET;
					pred_cr_q <= PRED_RESET;
					past_valid_q <= 1'b0;
				end
				REQ_COEF: begin
					if (pop_item.is_dc) begin
						if (!pop_item.block_num[2]) begin
							pred_luma_q <= dc_val;
						end else if (pop_item.block_num == 3'd4) begin
							pred_cb_q <= dc_val;
						end else begin
							pred_cr_q <= dc_val;
						end
					end
					if (pop_item.intra) begin
						past_addr_q <= pop_item.mb_address;
						past_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign weight_s1 = !wvld_s1 ? wdef_s1 : (intra_s1 ? rd_intra : rd_nonintra);

	always_comb begin
		mag = intra_s2 ? prod_s2[PROD_W-1:3] : {1'b0, prod_s2[PROD_W-1:4]};
		mag_odd = (mag != '0 && !mag[0]) ? mag - 19'd1 : mag;
		if (neg_s2) begin
			ac_val = (mag_odd > AC_NEG_MAX) ? -13'sd2048 : -$signed(RECON_W'(mag_odd));
		end else begin
			ac_val = (mag_odd > AC_POS_MAX) ? 13'sd2047 : $signed(RECON_W'(mag_odd));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= coef_pop;
			vld_s2 <= vld_s1;
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			is_dc_s1 <= pop_item.is_dc;
			dc_s1 <= dc_val;
			intra_s1 <= pop_item.intra;
			neg_s1 <= pop_item.negative;
			m1_s1 <= pop_item.m1;
			pos_s1 <= pop_item.pos;
			last_s1 <= pop_item.last;
			wvld_s1 <= pop_item.intra ? ivld_q[pop_item.pos] : nvld_q[pop_item.pos];
			wdef_s1 <= pop_item.intra ? INTRA_DEFAULT[pop_item.pos] : NONINTRA_DEFAULT;

			is_dc_s2 <= is_dc_s1;
			dc_s2 <= dc_s1;
			intra_s2 <= intra_s1;
			neg_s2 <= neg_s1;
			prod_s2 <= {{WEIGHT_W{1'b0}}, m1_s1} * {{M1_W{1'b0}}, weight_s1};
			pos_s2 <= pos_s1;
			last_s2 <= last_s1;

			recon_q <= is_dc_s2 ? dc_s2 : ac_val;
			position_q <= pos_s2;
			block_end_q <= last_s2;
		end
	end

	assign result.valid = out_vld_q;
	assign result.recon_value = recon_q;
	assign result.position = position_q;
	assign result.block_end = block_end_q;

endmodule

[rtl/mpeg1_inverse_quantizer_unit.sv]
// MPEG-1 inverse quantizer with intra DC prediction: top level.
// A coefficient beat's result passes through the queue and the s1, s2 and output registers.
// One beat is accepted per cycle while the queue has room; the back end takes one
// queued beat per cycle unless its output stalls. Load and slice beats yield no result.
// Reset restores both weight tables to their defaults through per-entry valid bits
// and sets the three DC predictors to 1024; no clearing pass is needed.
module mpeg1_inverse_quantizer_unit import mpeg1iq_pkg::*; (
	input logic clk,
	input logic arst_n,
	mpeg1iq_in_if.sink item,
	mpeg1iq_out_if.source result
);

	logic     push;
	iq_item_t push_item;
	logic     fifo_ready;
	logic     pop;
	logic     pop_valid;
	iq_item_t pop_item;

	mpeg1iq_front u_front (
		.item(item),
		.fifo_ready(fifo_ready),
		.push(push),
		.push_item(push_item)
	);

	mpeg1iq_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.push_ready(fifo_ready),
		.pop(pop),
		.pop_valid(pop_valid),
		.pop_item(pop_item)
	);

	mpeg1iq_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_item(pop_item),
		.pop(pop),
		.result(result)
	);

endmodule
